@@ sv/lnws_pkg.sv @@
// Shared types and constants for the LCD nibble write sequencer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lnws_pkg;

    localparam logic       OP_WRITE      = 1'b0;
    localparam logic       OP_CLEAR      = 1'b1;

    localparam logic [6:0] LINE1_END     = 7'h0F;
    localparam logic [6:0] LINE2_START   = 7'h40;
    localparam logic [6:0] LINE2_END     = 7'h4F;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SET_LINE2 = 8'hC0;

    localparam int unsigned RS_BIT       = 4;
    localparam int unsigned E_BIT        = 5;

    localparam logic [1:0] PH_E_LOW0     = 2'd0;
    localparam logic [1:0] PH_E_HIGH     = 2'd1;
    localparam logic [1:0] PH_E_LOW1     = 2'd2;

    // One classified item: a first byte with its RS, and an optional
    // command byte (always RS low) that follows it.
    typedef struct packed {
        logic [7:0] byte0;
        logic       rs0;
        logic [7:0] byte1;
        logic       two;
    } t_cmd;

endpackage

@@ sv/lnws_front.sv @@
// Front end of the LCD nibble write sequencer: accepts items, tracks the
// cursor and classifies each item into a byte pair. Depends on lnws_pkg.
module lnws_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_opcode,
    input  logic [7:0]      i_char_code,
    input  logic            i_full,
    output logic            o_stall,
    output logic            o_push,
    output lnws_pkg::t_cmd  o_cmd
);

    logic [6:0] r_pos;
    logic [6:0] n_pos;
    logic       accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        n_pos       = r_pos;
        o_cmd.byte0 = i_char_code;
        o_cmd.rs0   = 1'b1;
        o_cmd.byte1 = lnws_pkg::CMD_HOME;
        o_cmd.two   = 1'b0;
        if (i_opcode == lnws_pkg::OP_CLEAR) begin
            o_cmd.byte0 = lnws_pkg::CMD_CLEAR;
            o_cmd.rs0   = 1'b0;
            o_cmd.two   = 1'b1;
            n_pos       = '0;
        end else if (r_pos < lnws_pkg::LINE1_END ||
                     (r_pos >= lnws_pkg::LINE2_START && r_pos < lnws_pkg::LINE2_END)) begin
            n_pos = r_pos + 7'd1;
        end else if (r_pos == lnws_pkg::LINE1_END) begin
            // wrap onto the second line
            o_cmd.byte1 = lnws_pkg::CMD_SET_LINE2;
            o_cmd.two   = 1'b1;
            n_pos       = lnws_pkg::LINE2_START;
        end else if (r_pos == lnws_pkg::LINE2_END) begin
            o_cmd.two = 1'b1;
            n_pos     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

@@ sv/lnws_queue.sv @@
// Two-entry queue of classified items between front and back.
// Depends on lnws_pkg for the item type.
module lnws_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lnws_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lnws_pkg::t_cmd  o_cmd
);

    lnws_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/lnws_back.sv @@
// LCD nibble write sequencer back end, depends on lnws_pkg: splits the head
// item into nibbles and E strobe phases, one shift byte per unstalled cycle.
module lnws_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  lnws_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [5:0]      o_shift_byte,
    output logic            o_last
);

    logic [1:0] r_nib;
    logic [1:0] r_phase;
    logic       r_valid;
    logic [5:0] r_shift_byte;
    logic [5:0] n_shift_byte;
    logic       r_last;

    logic       out_ready;
    logic       fire;
    logic [3:0] nibble;
    logic       rs;
    logic       strobe;
    logic       final_byte;

    assign out_ready = !r_valid || !i_stall;
    assign fire      = out_ready && !i_empty;

    always_comb begin
        case (r_nib)
            2'd0:    nibble = i_cmd.byte0[7:4];
            2'd1:    nibble = i_cmd.byte0[3:0];
            2'd2:    nibble = i_cmd.byte1[7:4];
            default: nibble = i_cmd.byte1[3:0];
        endcase
        rs         = r_nib[1] ? 1'b0 : i_cmd.rs0;
        strobe     = (r_phase == lnws_pkg::PH_E_HIGH);
        final_byte = (r_phase == lnws_pkg::PH_E_LOW1) &&
                     ((r_nib == 2'd3) || (r_nib == 2'd1 && !i_cmd.two));
        n_shift_byte                   = {2'b00, nibble};
        n_shift_byte[lnws_pkg::RS_BIT] = rs;
        n_shift_byte[lnws_pkg::E_BIT]  = strobe;
    end

    assign o_pop        = fire && final_byte;
    assign o_valid      = r_valid;
    assign o_shift_byte = r_shift_byte;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nib   <= '0;
            r_phase <= lnws_pkg::PH_E_LOW0;
            r_valid <= 1'b0;
        end else if (fire) begin
            r_valid <= 1'b1;
            if (final_byte) begin
                r_nib   <= '0;
                r_phase <= lnws_pkg::PH_E_LOW0;
            end else if (r_phase == lnws_pkg::PH_E_LOW1) begin
                r_nib   <= r_nib + 2'd1;
                r_phase <= lnws_pkg::PH_E_LOW0;
            end else begin
                r_phase <= r_phase + 2'd1;
            end
        end else if (out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_shift_byte <= n_shift_byte;
            r_last       <= final_byte;
        end
    end

endmodule

@@ sv/lcd_nibble_write_sequencer_top.sv @@
// LCD nibble write sequencer, top level: character writes and clear requests
// in, 6-bit shift-register bytes out for a 4-bit-mode character LCD.
// Usage:
//   Input channel (i_in_valid / o_in_stall): one item per accept, carrying
//   i_opcode (0 write character, 1 clear and home) and i_char_code.
//   Output channel (o_out_valid / i_out_stall): one shift byte per accept,
//   bits 3:0 nibble, bit 4 RS, bit 5 E; o_last marks an item's final byte.
//   Each nibble goes out as E low, E high, E low. A character gives 6 bytes,
//   or 12 when it ends a line and a set-address or return-home follows.
//   A clear always gives 12 bytes and sends the cursor back to zero.
// Timing:
//   An accepted item is queued, and its first byte is then formed in the
//   back end's output register. The back end emits one byte per cycle
//   while the output is not stalled; sustained input rate is set by that
//   output serializer. A two-entry queue lets the front accept while
//   the back is still busy; o_in_stall rises only when the queue is full.
// Reset (synchronous, active low) zeros the cursor, empties the queue and
// drops any byte in flight. A stall on the output holds the current byte
// and freezes the serializer; the queue then fills and stalls the input.
module lcd_nibble_write_sequencer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [5:0] o_shift_byte,
    output logic       o_last
);

    lnws_pkg::t_cmd push_cmd;
    lnws_pkg::t_cmd head_cmd;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    // Classify items and advance the cursor.
    lnws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_full      (full),
        .o_stall     (o_in_stall),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Decouple the accept side from the serializer.
    lnws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // Serialize nibbles into strobed shift bytes.
    lnws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_shift_byte (o_shift_byte),
        .o_last       (o_last)
    );

endmodule

@@ tb/tb_lcd_nibble_write_sequencer_top.sv @@
// Self-checking bench for lcd_nibble_write_sequencer_top: queued character and clear items in,
// every shift byte compared against an in-bench cursor and nibble sequencer.
// Depends on lnws_pkg and the top-level RTL only.
module tb_lcd_nibble_write_sequencer_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 90;

    // One expected shift byte.
    typedef struct packed {
        logic [5:0] shift_byte;
        logic       last;
    } t_lcd_byte;

    // One pending input item; wait_drain holds it back until no byte is owed.
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       wait_drain;
    } t_lcd_req;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_opcode    = lnws_pkg::OP_WRITE;
    logic [7:0] i_char_code = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [5:0] o_shift_byte;
    logic       o_last;

    t_lcd_byte  shift_due [$];
    t_lcd_req   pending [$];
    logic [6:0] model_cursor = 7'd0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int accept_count  = 0;
    int offer_count   = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int hold_kick     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    lcd_nibble_write_sequencer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_shift_byte (o_shift_byte),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Expand one accepted item into its shift bytes and advance the cursor.
    task automatic predict_bytes(input logic op, input logic [7:0] ch);
        logic [7:0] seq [2];
        logic       seq_rs [2];
        int         n;
        int         i;
        int         h;
        int         p;
        logic [3:0] nib;
        t_lcd_byte  b;
        n = 1;
        if (op == lnws_pkg::OP_CLEAR) begin
            seq[0] = lnws_pkg::CMD_CLEAR;
            seq_rs[0] = 1'b0;
            seq[1] = lnws_pkg::CMD_HOME;
            seq_rs[1] = 1'b0;
            n = 2;
            model_cursor = 7'd0;
        end else begin
            seq[0] = ch;
            seq_rs[0] = 1'b1;
            if (model_cursor < lnws_pkg::LINE1_END ||
                (model_cursor >= lnws_pkg::LINE2_START &&
                 model_cursor < lnws_pkg::LINE2_END)) begin
                model_cursor = model_cursor + 7'd1;
            end else if (model_cursor == lnws_pkg::LINE1_END) begin
                // end of the first line: jump to the second line's address
                seq[1] = lnws_pkg::CMD_SET_LINE2;
                seq_rs[1] = 1'b0;
                n = 2;
                model_cursor = lnws_pkg::LINE2_START;
            end else if (model_cursor == lnws_pkg::LINE2_END) begin
                // end of the second line: home and wrap
                seq[1] = lnws_pkg::CMD_HOME;
                seq_rs[1] = 1'b0;
                n = 2;
                model_cursor = 7'd0;
            end
        end
        for (i = 0; i < n; i++) begin
            for (h = 0; h < 2; h++) begin
                nib = (h == 0) ? seq[i][7:4] : seq[i][3:0];
                for (p = lnws_pkg::PH_E_LOW0; p <= lnws_pkg::PH_E_LOW1; p++) begin
                    b.shift_byte = {2'b00, nib};
                    b.shift_byte[lnws_pkg::RS_BIT] = seq_rs[i];
                    b.shift_byte[lnws_pkg::E_BIT] = (p == lnws_pkg::PH_E_HIGH);
                    b.last = (i == n - 1) && (h == 1) && (p == lnws_pkg::PH_E_LOW1);
                    shift_due.push_back(b);
                end
            end
        end
    endtask

    task automatic queue_item(input logic op, input logic [7:0] ch, input logic wait_drain);
        t_lcd_req r;
        r.op = op;
        r.ch = ch;
        r.wait_drain = wait_drain;
        pending.push_back(r);
    endtask

    // Mostly writes so the cursor walks across both line ends; clears now and then unless writes_only.
    task automatic queue_random(input int count, input bit writes_only);
        int k;
        for (k = 0; k < count; k++) begin
            if (!writes_only && $urandom_range(29) == 0) begin
                queue_item(lnws_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'b0);
            end else begin
                queue_item(lnws_pkg::OP_WRITE, 8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || accept_count != offer_count || shift_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sample at the rising edge: check output bytes, predict from accepted items, watch the clock.
    always @(posedge i_clk) begin
        t_lcd_byte got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lcd_nibble_write_sequencer_top verification failed");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (shift_due.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing owed", o_shift_byte));
                end else begin
                    got = shift_due.pop_front();
                    if (o_shift_byte !== got.shift_byte) begin
                        report_mismatch($sformatf("shift_byte %02h, want %02h",
                                                  o_shift_byte, got.shift_byte));
                    end
                    if (o_last !== got.last) begin
                        report_mismatch($sformatf("last %b, want %b", o_last, got.last));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_bytes(i_opcode, i_char_code);
                accept_count++;
            end
        end
    end

    // Driver: hold an offered item until taken, then idle or present the next one.
    always @(negedge i_clk) begin
        t_lcd_req r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && accept_count != offer_count) begin
            // hold the stalled item
        end else if (pending.size() == 0 || $urandom_range(99) < send_idle_pct ||
                     (pending[0].wait_drain && shift_due.size() != 0)) begin
            i_in_valid <= 1'b0;
        end else begin
            r = pending.pop_front();
            i_opcode <= r.op;
            i_char_code <= r.ch;
            i_in_valid <= 1'b1;
            offer_count++;
        end
    end

    // Receiver: random stalls, plus a long hold-off each time hold_kick moves.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        int k;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles a little, receiver a lot.
        send_idle_pct = 23;
        recv_idle_pct = 83;
        // Directed: clear first, byte extremes, walk to the end of line one.
        queue_item(lnws_pkg::OP_CLEAR, 8'hFF, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'h00, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'hFF, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'h0F, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'hF0, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'hA5, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'h5A, 1'b0);
        for (k = 0; k < 9; k++) begin
            queue_item(lnws_pkg::OP_WRITE, 8'($urandom_range(255)), 1'b0);
        end
        // sixteenth write crosses to line two; clear mid-line after one more
        queue_item(lnws_pkg::OP_WRITE, 8'h7F, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'h80, 1'b0);
        queue_item(lnws_pkg::OP_CLEAR, 8'h00, 1'b0);
        queue_item(lnws_pkg::OP_WRITE, 8'h41, 1'b0);
        queue_item(lnws_pkg::OP_CLEAR, 8'h5A, 1'b1);
        queue_random(60, 1'b0);
        wait_drained();

        // Phase two: roles swapped; a long write run crosses both line ends.
        send_idle_pct = 83;
        recv_idle_pct = 23;
        queue_random(20, 1'b1);
        queue_item(lnws_pkg::OP_WRITE, 8'($urandom_range(255)), 1'b1);
        queue_random(20, 1'b1);
        queue_random(20, 1'b0);
        wait_drained();

        // Phase three: no idling, one long receiver hold-off to back up the queue.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(40, 1'b0);
        hold_kick = hold_kick + 1;
        wait_drained();

        repeat (30) @(negedge i_clk);
        if (error_count == 0) begin
            $display("lcd_nibble_write_sequencer_top verification clean");
        end else begin
            $display("lcd_nibble_write_sequencer_top verification failed");
        end
        $finish;
    end

endmodule
